// ===== sv/silence_split_segment_detector_unit_assert.svh =====
// Assertion macros for the silence split segment detector.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SILENCE_SPLIT_SEGMENT_DETECTOR_UNIT_ASSERT_SVH
`define SILENCE_SPLIT_SEGMENT_DETECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ssd_pkg.sv =====
// Shared types and constants for the silence split segment detector.
// No dependencies; imported by every module of the block.
package ssd_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W   = 24;
    localparam int MAG_W      = 24;
    localparam int SIL_W      = 32;
    localparam int CHCNT_W    = 4;
    localparam int INDEX_W    = 16;
    localparam int FRAME_W    = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top level parameters
    localparam int DEF_MAX_CHANNELS  = 8;
    localparam int DEF_POSITION_BITS = 48;

    // Segments shorter than this many frames, unless closed by a flush, are outliers
    localparam int OUTLIER_FRAMES = 10;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [MAG_W-1:0]   RST_THRESHOLD   = 24'd512;
    localparam logic [23:0]        RST_MIN_SILENCE = 24'd240000;
    localparam logic [CHCNT_W-1:0] RST_CHANNELS    = 4'd2;
    localparam logic [SIL_W-1:0]   RST_INIT_SIL    = 32'd384000;

    // Segment number after reset, so the first segment gets index zero
    localparam logic [INDEX_W-1:0] RST_SEGNUM = '1;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SILENCE_THRESHOLD     = 2'd0,
        REG_MIN_SILENCE_FRAMES    = 2'd1,
        REG_CHANNEL_COUNT         = 2'd2,
        REG_INITIAL_SILENCE_COUNT = 2'd3
    } cfg_reg_t;

    // Input command codes
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_FLUSH  = 1'b1
    } cmd_t;

    // Result kind codes
    typedef enum logic {
        KIND_SEGMENT = 1'b0,
        KIND_OUTLIER = 1'b1
    } kind_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] segment_index;
        logic [FRAME_W-1:0] start_frame;
        logic [FRAME_W-1:0] end_frame;
        logic [MAG_W-1:0]   peak_level;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic             flush;
        logic             quiet;
        logic [MAG_W-1:0] mag;
    } cls_item_t;

    // Configuration register contents
    typedef struct packed {
        logic [MAG_W-1:0]   threshold;
        logic [23:0]        min_silence;
        logic [CHCNT_W-1:0] channels;
        logic [SIL_W-1:0]   init_silence;
    } cfg_t;

    // Back end status for checking
    typedef struct packed {
        logic dividing;
        logic emitting;
    } bk_status_t;

endpackage

// ===== sv/silence_split_segment_detector_unit.sv =====
// Silence split segment detector. Each sample transaction is classified on entry
// and queued; the back end retires one queued sample per cycle while in BK_IDLE.
// A sample that closes a segment, and a flush with an open segment, go through
// BK_DIV, where the bit-serial divider forms silence count over channel count,
// then BK_EMIT, which holds while the previous result still waits to be taken.
// The queue holds four items, and one result waits in the output register.
// Configuration writes are registered before use and must come while idle.
// Depends on ssd_pkg, ssd_front, ssd_queue, ssd_back and the assertion header.
`include "silence_split_segment_detector_unit_assert.svh"

module silence_split_segment_detector_unit #(
    parameter int MAX_CHANNELS  = ssd_pkg::DEF_MAX_CHANNELS,
    parameter int POSITION_BITS = ssd_pkg::DEF_POSITION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ssd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  ssd_pkg::in_item_t                    item,
    input  logic                                 push,
    output logic                                 full,
    output ssd_pkg::out_item_t                   result,
    output logic                                 empty,
    input  logic                                 pop
);
    import ssd_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       q_full, q_empty, q_push, q_pop;
    cls_item_t  q_wr_data, q_rd_data;
    bk_status_t bk_status;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_SILENCE_THRESHOLD:     cfg_next.threshold    = cfg_wdata[MAG_W-1:0];
                REG_MIN_SILENCE_FRAMES:    cfg_next.min_silence  = cfg_wdata[23:0];
                REG_CHANNEL_COUNT:         cfg_next.channels     = cfg_wdata[CHCNT_W-1:0];
                REG_INITIAL_SILENCE_COUNT: cfg_next.init_silence = cfg_wdata[SIL_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= RST_THRESHOLD;
            cfg_reg.min_silence  <= RST_MIN_SILENCE;
            cfg_reg.channels     <= RST_CHANNELS;
            cfg_reg.init_silence <= RST_INIT_SIL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssd_front u_front (
        .item   (item),
        .push   (push),
        .full   (full),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    ssd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    ssd_back #(
        .MAX_CHANNELS  (MAX_CHANNELS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .status  (bk_status)
    );

    // An accepted transaction is queued on the next cycle
    `SSD_ASSERT_NEXT(a_push_queued, push && !full, !q_empty, "accepted item not queued")
    // A result is only written into an empty output register
    `SSD_ASSERT_NOW(a_emit_slot_free, bk_status.emitting, empty, "result overwritten")
    // Division starts only from an item taken off the queue
    `SSD_ASSERT_NOW(a_div_from_pop, $rose(bk_status.dividing), $past(q_pop),
                    "divider started without an item")

endmodule

// ===== sv/ssd_front.sv =====
// Front end: accepts input transactions and classifies each sample.
// Depends on ssd_pkg.
module ssd_front (
    input  ssd_pkg::in_item_t  item,
    input  logic               push,
    output logic               full,
    input  ssd_pkg::cfg_t      cfg,
    input  logic               q_full,
    output logic               q_push,
    output ssd_pkg::cls_item_t q_data
);
    import ssd_pkg::*;

    logic [MAG_W-1:0] raw;
    logic [MAG_W-1:0] mag;

    // Take magnitude of the two's complement sample
    assign raw = MAG_W'(item.sample);
    assign mag = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;

    // Accept whenever the queue has room
    assign full   = q_full;
    assign q_push = push && !q_full;

    // Classify: flush command, or quiet against the threshold
    always_comb
    begin
        q_data.flush = (item.cmd == CMD_FLUSH);
        q_data.quiet = (mag < cfg.threshold);
        q_data.mag   = mag;
    end

endmodule

// ===== sv/ssd_queue.sv =====
// Small queue between front and back ends of the segment detector.
// Depends on ssd_pkg.
module ssd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  ssd_pkg::cls_item_t wr_data,
    input  logic               rd_en,
    output ssd_pkg::cls_item_t rd_data,
    output logic               q_full,
    output logic               q_empty
);
    import ssd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign q_full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/ssd_back.sv =====
// Back end: segment state, bit-serial divider and result register.
// Depends on ssd_pkg.
module ssd_back #(
    parameter int MAX_CHANNELS  = ssd_pkg::DEF_MAX_CHANNELS,
    parameter int POSITION_BITS = ssd_pkg::DEF_POSITION_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssd_pkg::cfg_t          cfg,
    input  logic                   q_empty,
    input  ssd_pkg::cls_item_t     q_data,
    output logic                   q_pop,
    output logic                   empty,
    input  logic                   pop,
    output ssd_pkg::out_item_t     result,
    output ssd_pkg::bk_status_t    status
);
    import ssd_pkg::*;

    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int CP_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NEED_W = 24 + CH_W;
    localparam int CNT_W  = $clog2(SIL_W);
    localparam int PB     = POSITION_BITS;

    bk_state_t         st_reg, st_next;
    logic [PB-1:0]     frame_reg, frame_next;
    logic [CP_W-1:0]   chan_reg, chan_next;
    logic [SIL_W-1:0]  sil_reg, sil_next;
    logic [PB-1:0]     start_reg, start_next;
    logic [MAG_W-1:0]  peak_reg, peak_next;
    logic [INDEX_W-1:0] segnum_reg, segnum_next;
    logic              flush_reg, flush_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [CH_W-1:0]   rem_reg, rem_next;
    logic [SIL_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CH_W-1:0]   eff_ch_reg, eff_ch_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic [CP_W:0]     chan_inc;
    logic              chan_wrap;
    logic [CP_W-1:0]   adv_chan;
    logic [PB-1:0]     adv_frame;
    logic              seg_open;
    logic              enough;
    logic [CH_W:0]     shifted;
    logic              div_ge;
    logic [PB-1:0]     end_pos;
    logic [PB-1:0]     seg_len;
    logic              outlier;
    logic [63:0]       start_wide;
    logic [63:0]       end_wide;

    // Clamp channel count and form the silence needed for a new segment
    always_comb
    begin
        if (cfg.channels == '0)
        begin
            eff_ch_next = CH_W'(1);
        end
        else if ((CH_W + CHCNT_W)'(cfg.channels) > (CH_W + CHCNT_W)'(MAX_CHANNELS))
        begin
            eff_ch_next = CH_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_ch_next = CH_W'(cfg.channels);
        end
        need_next = NEED_W'(cfg.min_silence) * NEED_W'(eff_ch_next);
    end

    // Channel and frame advance after a sample
    assign chan_inc  = {1'b0, chan_reg} + (CP_W + 1)'(1);
    assign chan_wrap = ((CH_W + CP_W + 1)'(chan_inc) >= (CH_W + CP_W + 1)'(eff_ch_reg));
    assign adv_chan  = chan_wrap ? '0 : chan_inc[CP_W-1:0];
    assign adv_frame = chan_wrap ? frame_reg + PB'(1) : frame_reg;

    assign seg_open = (start_reg != '0);
    assign enough   = (sil_reg >= SIL_W'(need_reg));

    // One restoring divider step: silence count over channel count
    assign shifted = {rem_reg, quo_reg[SIL_W-1]};
    assign div_ge  = (shifted >= {1'b0, eff_ch_reg});

    // Segment end and length from the quotient
    assign end_pos = frame_reg - PB'(quo_reg) + (flush_reg ? PB'(1) : PB'(0));
    assign seg_len = end_pos - start_reg;
    assign outlier = !flush_reg && (seg_len < PB'(OUTLIER_FRAMES));

    assign start_wide = 64'(start_reg);
    assign end_wide   = 64'(end_pos);

    // Sequencer: take items, divide when a segment closes, emit the result
    always_comb
    begin
        st_next        = st_reg;
        frame_next     = frame_reg;
        chan_next      = chan_reg;
        sil_next       = sil_reg;
        start_next     = start_reg;
        peak_next      = peak_reg;
        segnum_next    = segnum_reg;
        flush_next     = flush_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        status         = '0;

        // Drop the result once taken
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (st_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.flush)
                    begin
                        if (seg_open)
                        begin
                            flush_next = 1'b1;
                            mag_next   = q_data.mag;
                            rem_next   = '0;
                            quo_next   = sil_reg;
                            cnt_next   = '0;
                            st_next    = BK_DIV;
                        end
                        else
                        begin
                            frame_next  = '0;
                            chan_next   = '0;
                            sil_next    = cfg.init_silence;
                            start_next  = '0;
                            peak_next   = '0;
                            segnum_next = RST_SEGNUM;
                        end
                    end
                    else if (q_data.quiet)
                    begin
                        if (sil_reg != '1)
                        begin
                            sil_next = sil_reg + 1'b1;
                        end
                        frame_next = adv_frame;
                        chan_next  = adv_chan;
                    end
                    else if (enough && seg_open)
                    begin
                        flush_next = 1'b0;
                        mag_next   = q_data.mag;
                        rem_next   = '0;
                        quo_next   = sil_reg;
                        cnt_next   = '0;
                        st_next    = BK_DIV;
                    end
                    else
                    begin
                        // Loud sample with no segment to close
                        if (enough)
                        begin
                            segnum_next = segnum_reg + 1'b1;
                            start_next  = frame_reg;
                            peak_next   = q_data.mag;
                        end
                        else if (peak_reg < q_data.mag)
                        begin
                            peak_next = q_data.mag;
                        end
                        sil_next   = '0;
                        frame_next = adv_frame;
                        chan_next  = adv_chan;
                    end
                end
            end

            BK_DIV:
            begin
                status.dividing = 1'b1;
                rem_next = div_ge ? CH_W'(shifted - {1'b0, eff_ch_reg}) : shifted[CH_W-1:0];
                quo_next = {quo_reg[SIL_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SIL_W - 1))
                begin
                    st_next = BK_EMIT;
                end
            end

            BK_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    status.emitting        = 1'b1;
                    out_valid_next         = 1'b1;
                    out_next.kind          = outlier ? KIND_OUTLIER : KIND_SEGMENT;
                    out_next.segment_index = segnum_reg;
                    out_next.start_frame   = start_wide[FRAME_W-1:0];
                    out_next.end_frame     = end_wide[FRAME_W-1:0];
                    out_next.peak_level    = peak_reg;
                    if (flush_reg)
                    begin
                        frame_next  = '0;
                        chan_next   = '0;
                        sil_next    = cfg.init_silence;
                        start_next  = '0;
                        peak_next   = '0;
                        segnum_next = RST_SEGNUM;
                    end
                    else
                    begin
                        // An outlier keeps its index for the next segment
                        if (!outlier)
                        begin
                            segnum_next = segnum_reg + 1'b1;
                        end
                        start_next = frame_reg;
                        peak_next  = mag_reg;
                        sil_next   = '0;
                        frame_next = adv_frame;
                        chan_next  = adv_chan;
                    end
                    st_next = BK_IDLE;
                end
            end

            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_IDLE;
            frame_reg     <= '0;
            chan_reg      <= '0;
            sil_reg       <= RST_INIT_SIL;
            start_reg     <= '0;
            peak_reg      <= '0;
            segnum_reg    <= RST_SEGNUM;
            eff_ch_reg    <= CH_W'(RST_CHANNELS);
            need_reg      <= NEED_W'(RST_MIN_SILENCE) * NEED_W'(RST_CHANNELS);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            frame_reg     <= frame_next;
            chan_reg      <= chan_next;
            sil_reg       <= sil_next;
            start_reg     <= start_next;
            peak_reg      <= peak_next;
            segnum_reg    <= segnum_next;
            eff_ch_reg    <= eff_ch_next;
            need_reg      <= need_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload and divider datapath
    always_ff @(posedge clk)
    begin
        flush_reg <= flush_next;
        mag_reg   <= mag_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        out_reg   <= out_next;
    end

endmodule

// ===== bench/silence_split_segment_detector_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for silence_split_segment_detector_unit: directed tests, then shaped
// random segments, with every report predicted here and compared. Depends on ssd_pkg.
module silence_split_segment_detector_unit_test;
    import ssd_pkg::*;

    // Covers the queue, the output register and one divide per waiting item
    localparam int DRAIN_CYCLES   = 240;
    localparam int RANDOM_ITEMS   = 850;
    localparam int RANDOM_REPORTS = 40;
    localparam logic [MAG_W-1:0] FULL_SCALE = 24'h800000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    in_item_t              item;
    logic                  push;
    logic                  full;
    out_item_t             result;
    logic                  empty;
    logic                  pop = 1'b0;

    // Register mirror
    logic [MAG_W-1:0]   cfg_threshold;
    logic [23:0]        cfg_min_silence;
    logic [CHCNT_W-1:0] cfg_channels;
    logic [SIL_W-1:0]   cfg_init_silence;

    // Detector state mirror
    logic [FRAME_W-1:0] frame_pos;
    int unsigned        chan_idx;
    logic [SIL_W-1:0]   quiet_run;
    logic [FRAME_W-1:0] open_start;
    logic [MAG_W-1:0]   peak_mag;
    logic [INDEX_W-1:0] seg_num;

    out_item_t   expected_reports[$];
    int unsigned reports_predicted;
    int unsigned items_sent;
    int unsigned faults;

    // Sender burst shaping
    int unsigned burst_left;
    int unsigned gap_len;
    bit          steady_stretch;

    // Receiver stall pattern
    int unsigned drain_mode;
    int unsigned mode_left;

    silence_split_segment_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .push      (push),
        .full      (full),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned lanes_per_frame();
        if (cfg_channels == '0)
            return 1;
        if (cfg_channels > CHCNT_W'(DEF_MAX_CHANNELS))
            return DEF_MAX_CHANNELS;
        return 32'(cfg_channels);
    endfunction

    function automatic void clear_tracking();
        frame_pos  = '0;
        chan_idx   = 0;
        quiet_run  = cfg_init_silence;
        open_start = '0;
        peak_mag   = '0;
        seg_num    = RST_SEGNUM;
    endfunction

    function automatic void queue_report(input kind_t kind, input logic [INDEX_W-1:0] idx,
                                         input logic [FRAME_W-1:0] seg_end);
        out_item_t rpt;
        rpt.kind          = kind;
        rpt.segment_index = idx;
        rpt.start_frame   = open_start;
        rpt.end_frame     = seg_end;
        rpt.peak_level    = peak_mag;
        expected_reports.insert(expected_reports.size(), rpt);
        reports_predicted++;
    endfunction

    // Advance the segment tracker by one input transaction
    function automatic void track_segments(input in_item_t it);
        int unsigned        lanes;
        logic [24:0]        wide;
        logic [MAG_W-1:0]   mag;
        logic [63:0]        need;
        logic [FRAME_W-1:0] seg_end;
        logic [FRAME_W-1:0] span;
        logic [INDEX_W-1:0] idx;
        lanes = lanes_per_frame();
        if (it.cmd == CMD_FLUSH)
        begin
            if (open_start != '0)
            begin
                seg_end = frame_pos - FRAME_W'(quiet_run / lanes) + FRAME_W'(1);
                queue_report(KIND_SEGMENT, seg_num, seg_end);
            end
            clear_tracking();
            return;
        end
        wide = it.sample[SAMPLE_W-1] ? (25'h1000000 - {1'b0, it.sample}) : {1'b0, it.sample};
        mag  = wide[MAG_W-1:0];
        if (mag < cfg_threshold)
        begin
            if (quiet_run != '1)
                quiet_run++;
        end
        else
        begin
            need = 64'(cfg_min_silence) * 64'(lanes);
            if (64'(quiet_run) >= need)
            begin
                // Close the open segment; a short one gives its index back
                if (open_start != '0)
                begin
                    seg_end = frame_pos - FRAME_W'(quiet_run / lanes);
                    span    = seg_end - open_start;
                    idx     = seg_num;
                    if (span < FRAME_W'(OUTLIER_FRAMES))
                    begin
                        seg_num = seg_num - 1'b1;
                        queue_report(KIND_OUTLIER, idx, seg_end);
                    end
                    else
                        queue_report(KIND_SEGMENT, idx, seg_end);
                end
                seg_num    = seg_num + 1'b1;
                open_start = frame_pos;
                peak_mag   = '0;
            end
            if (peak_mag < mag)
                peak_mag = mag;
            quiet_run = '0;
        end
        chan_idx++;
        if (chan_idx >= lanes)
        begin
            chan_idx  = 0;
            frame_pos = frame_pos + 1'b1;
        end
    endfunction

    function automatic void compare_field(input string label, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            faults++;
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
        end
    endfunction

    // Track register writes, accepted samples and accepted reports
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cfg_threshold    = RST_THRESHOLD;
            cfg_min_silence  = RST_MIN_SILENCE;
            cfg_channels     = RST_CHANNELS;
            cfg_init_silence = RST_INIT_SIL;
            clear_tracking();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_SILENCE_THRESHOLD:     cfg_threshold    = cfg_wdata[MAG_W-1:0];
                    REG_MIN_SILENCE_FRAMES:    cfg_min_silence  = cfg_wdata[23:0];
                    REG_CHANNEL_COUNT:         cfg_channels     = cfg_wdata[CHCNT_W-1:0];
                    REG_INITIAL_SILENCE_COUNT: cfg_init_silence = cfg_wdata[SIL_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                track_segments(item);
            if (pop && !empty)
            begin
                if (expected_reports.size() == 0)
                begin
                    faults++;
                    $display("%0t: report expected none actual index %0d start %0d end %0d",
                             $time, result.segment_index, result.start_frame,
                             result.end_frame);
                end
                else
                begin
                    out_item_t want;
                    want = expected_reports.pop_front();
                    compare_field("kind", 64'(want.kind), 64'(result.kind));
                    compare_field("segment_index", 64'(want.segment_index),
                                  64'(result.segment_index));
                    compare_field("start_frame", 64'(want.start_frame),
                                  64'(result.start_frame));
                    compare_field("end_frame", 64'(want.end_frame), 64'(result.end_frame));
                    compare_field("peak_level", 64'(want.peak_level),
                                  64'(result.peak_level));
                end
            end
        end
    end

    // Stall the result side in changing patterns, long holds included
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                drain_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 160);
            end
            else
                mode_left--;
            case (drain_mode)
                0:       pop <= 1'b1;
                1:       pop <= ($urandom_range(0, 3) != 0);
                2:       pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((mode_left % 48) < 8);
            endcase
        end
    end

    // Send one transaction, then idle between bursts
    task automatic send_item(input cmd_t op, input logic [SAMPLE_W-1:0] smp);
        item <= '{cmd: op, sample: smp};
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_len    = steady_stretch ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 7) == 0)
                steady_stretch = !steady_stretch;
        end
        burst_left--;
        if (gap_len != 0 && burst_left == 0)
        begin
            push <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
    endtask

    // Hold off until every report is in and the pipeline has drained
    task automatic settle();
        if (push)
            push <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers, with noise in the unused upper bits
    task automatic load_config(input logic [MAG_W-1:0] thr, input logic [23:0] min_frames,
                               input logic [CHCNT_W-1:0] lanes, input logic [SIL_W-1:0] init);
        cfg_reg_t          order [4];
        logic [CFG_DATA_W-1:0] data [4];
        order = '{REG_SILENCE_THRESHOLD, REG_MIN_SILENCE_FRAMES, REG_CHANNEL_COUNT,
                  REG_INITIAL_SILENCE_COUNT};
        data  = '{{8'($urandom), thr}, {8'($urandom), min_frames},
                  {28'($urandom), lanes}, init};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= order[i];
            cfg_wdata <= data[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] signed_from_mag(input logic [MAG_W-1:0] mag);
        if (mag == FULL_SCALE)
            return FULL_SCALE;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [SAMPLE_W-1:0] loud_sample();
        return signed_from_mag(MAG_W'($urandom_range(FULL_SCALE, cfg_threshold)));
    endfunction

    function automatic logic [SAMPLE_W-1:0] quiet_sample();
        if (cfg_threshold == '0)
            return loud_sample();
        return signed_from_mag(MAG_W'($urandom_range(cfg_threshold - 1, 0)));
    endfunction

    // Short segments, index reuse, and the segment opened at frame zero
    task automatic test_outlier_reuse();
        settle();
        load_config(24'd100, 24'd1, 4'd1, 32'd5);
        send_item(CMD_FLUSH, 24'h123456);
        send_item(CMD_SAMPLE, 24'd5000);
        send_item(CMD_SAMPLE, 24'd3);
        send_item(CMD_SAMPLE, -24'sd700);
        send_item(CMD_SAMPLE, 24'd800);
        send_item(CMD_SAMPLE, -24'sd99);
        send_item(CMD_SAMPLE, 24'd100);
        send_item(CMD_SAMPLE, 24'd0);
        send_item(CMD_SAMPLE, -24'sd101);
        send_item(CMD_FLUSH, 24'h000000);
    endtask

    // Zero threshold, zero minimum silence and channel count zero
    task automatic test_every_loud_opens();
        settle();
        load_config(24'd0, 24'd0, 4'd0, 32'd0);
        send_item(CMD_SAMPLE, FULL_SCALE);
        send_item(CMD_SAMPLE, 24'h7FFFFF);
        send_item(CMD_SAMPLE, 24'd0);
        send_item(CMD_SAMPLE, 24'hFFFFFF);
        send_item(CMD_FLUSH, 24'hFFFFFF);
    endtask

    // Largest registers, channel count above the limit, saturated silence
    task automatic test_saturation_extremes();
        settle();
        load_config(FULL_SCALE, 24'hFFFFFF, 4'd15, 32'hFFFFFFFF);
        send_item(CMD_FLUSH, 24'h0);
        for (int i = 0; i < DEF_MAX_CHANNELS; i++)
            send_item(CMD_SAMPLE, (i % 2) ? 24'h7FFFFF : 24'h800001);
        send_item(CMD_SAMPLE, FULL_SCALE);
        send_item(CMD_SAMPLE, 24'h7FFFFF);
        send_item(CMD_FLUSH, 24'h0);
    endtask

    // Shrink the channel count in the middle of a frame
    task automatic test_channel_change();
        settle();
        load_config(24'd16, 24'd0, 4'd3, 32'd0);
        send_item(CMD_SAMPLE, 24'd40);
        send_item(CMD_SAMPLE, -24'sd41);
        settle();
        load_config(24'd16, 24'd0, 4'd1, 32'd0);
        send_item(CMD_SAMPLE, 24'd42);
        send_item(CMD_SAMPLE, 24'd43);
        send_item(CMD_SAMPLE, -24'sd44);
        send_item(CMD_FLUSH, 24'h0);
    endtask

    // Loud runs of random length separated by silences near the minimum
    task automatic stream_segments(input int unsigned count);
        int unsigned first;
        int unsigned lanes;
        int unsigned frames;
        int unsigned pick;
        first = items_sent;
        while (items_sent - first < count)
        begin
            lanes  = lanes_per_frame();
            frames = $urandom_range(1, 14);
            for (int unsigned i = 0; i < frames * lanes; i++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    send_item(CMD_SAMPLE, 24'($urandom));
                else if (pick == 1)
                    send_item(CMD_SAMPLE, quiet_sample());
                else
                    send_item(CMD_SAMPLE, loud_sample());
            end
            // Mostly long enough silences, sometimes one frame short
            frames = cfg_min_silence + $urandom_range(0, 2);
            if (cfg_min_silence != '0 && $urandom_range(0, 4) == 0)
                frames = cfg_min_silence - 1;
            for (int unsigned i = 0; i < frames * lanes + $urandom_range(0, lanes - 1); i++)
                send_item(CMD_SAMPLE, quiet_sample());
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_FLUSH, 24'($urandom));
        end
    endtask

    task automatic test_random_segments();
        int unsigned first_item;
        int unsigned first_report;
        int unsigned phase;
        logic [MAG_W-1:0]   thr;
        logic [CHCNT_W-1:0] lanes;
        logic [SIL_W-1:0]   init;
        first_item   = items_sent;
        first_report = reports_predicted;
        phase        = 0;
        while ((items_sent - first_item < RANDOM_ITEMS ||
                reports_predicted - first_report < RANDOM_REPORTS) && phase < 24)
        begin
            case ($urandom_range(0, 3))
                0:       thr = MAG_W'($urandom_range(1, 255));
                1:       thr = MAG_W'($urandom_range(1, FULL_SCALE));
                2:       thr = FULL_SCALE;
                default: thr = MAG_W'(1);
            endcase
            lanes = ($urandom_range(0, 3) == 0) ? CHCNT_W'($urandom_range(0, 15)) :
                                                  CHCNT_W'($urandom_range(1, 3));
            case ($urandom_range(0, 3))
                0:       init = '0;
                1:       init = $urandom_range(0, 20);
                2:       init = '1;
                default: init = $urandom;
            endcase
            settle();
            load_config(thr, 24'($urandom_range(0, 4)), lanes, init);
            // Restart the stream so the new initial silence applies
            send_item(CMD_FLUSH, 24'($urandom));
            stream_segments(120);
            phase++;
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_addr       <= '0;
        cfg_wdata      <= '0;
        item           <= '0;
        push           <= 1'b0;
        burst_left     = 0;
        gap_len        = 0;
        steady_stretch = 1'b0;
        drain_mode     = 0;
        mode_left      = 0;
        faults         = 0;
        items_sent     = 0;
        reports_predicted = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_outlier_reuse();
        test_every_loud_opens();
        test_saturation_extremes();
        test_channel_change();
        test_random_segments();
        settle();
        if (faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
